@@ sv/gtrvp_pkg.sv @@
package gtrvp_pkg;

   localparam int SizeW = 48;
   localparam int IdW   = 32;

   // one input word
   typedef struct packed {
      logic             candidate_valid;
      logic [SizeW-1:0] candidate_ram;
      logic [SizeW-1:0] candidate_disk;
      logic [IdW-1:0]   candidate_id;
      logic [SizeW-1:0] ram_deficit;
      logic [SizeW-1:0] disk_deficit;
      logic             set_last;
   } req_type;

   // one result word
   typedef struct packed {
      logic             victim_valid;
      logic [IdW-1:0]   victim_id;
      logic [SizeW-1:0] ram_left;
      logic [SizeW-1:0] disk_left;
      logic             result_last;
   } rsp_type;

   // candidate held in one cell
   typedef struct packed {
      logic [SizeW-1:0] ram;
      logic [SizeW-1:0] disk;
      logic [IdW-1:0]   id;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SORT,
      OP_PICK
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_PICK
   } state_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      cell_op_type      op;
      logic             by_ram;
      logic             parity;
      logic [SizeW-1:0] ram_need;
      logic [SizeW-1:0] disk_need;
   } cell_ctl_type;

   // a sorts strictly before b: smaller key, then smaller id
   function automatic logic sorts_before(entry_type a, entry_type b, logic by_ram);
      logic [SizeW-1:0] ka;
      logic [SizeW-1:0] kb;
      ka = by_ram ? a.ram : a.disk;
      kb = by_ram ? b.ram : b.disk;
      if (ka != kb) begin
         return ka < kb;
      end
      return a.id < b.id;
   endfunction

endpackage

@@ sv/gtrvp_cell.sv @@
module gtrvp_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  gtrvp_pkg::cell_ctl_type ctl,
   input  logic                    no_cover,
   input  logic                    wr,
   input  gtrvp_pkg::entry_type    wr_entry,
   input  logic                    occ,
   input  logic                    occ_right,
   input  gtrvp_pkg::entry_type    left_entry,
   input  gtrvp_pkg::entry_type    right_entry,
   input  logic                    swap_in,
   input  logic                    found_in,
   input  logic                    shift_in,
   output gtrvp_pkg::entry_type    entry,
   output logic                    swap_out,
   output logic                    found_out,
   output logic                    shift_out,
   output logic                    victim
);
   import gtrvp_pkg::*;

   // parity of the transposition pass in which this cell is the left of a pair
   localparam logic PairParity = 1'(IDX % 2);

   entry_type entry_ff;
   entry_type entry_in;
   logic      covers;

   assign entry = entry_ff;

   // this candidate alone clears both deficits
   assign covers    = occ & (entry_ff.ram >= ctl.ram_need) & (entry_ff.disk >= ctl.disk_need);
   assign found_out = found_in | covers;

   // first covering cell, or the last occupied cell when nothing covers
   assign victim    = occ & ((covers & ~found_in) | (~occ_right & no_cover));
   assign shift_out = shift_in | victim;

   // compare-exchange with the right neighbor on this cell's pass parity
   assign swap_out = (ctl.parity == PairParity) & occ & occ_right &
                     sorts_before(right_entry, entry_ff, ctl.by_ram);

   always_comb begin
      entry_in = entry_ff;
      if (wr) begin
         entry_in = wr_entry;
      end else begin
         unique case (ctl.op)
            OP_SORT: begin
               if (swap_out) begin
                  entry_in = right_entry;
               end else if (swap_in) begin
                  entry_in = left_entry;
               end
            end
            OP_PICK: begin
               // close the gap left by the victim
               if (shift_out) begin
                  entry_in = right_entry;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ sv/greedy_two_resource_victim_picker.sv @@
// Channel   Ports                      Handshake
// input     start, busy, req_word      word taken when start & ~busy
// result    rsp_strobe, rsp_word       word valid for one cycle, always taken
//
// A word without set_last is taken every cycle while busy is low; a valid
// candidate in it loads one cell if the chain has room. A closing word with
// nothing to do gives one empty result on the next cycle. Otherwise the chain
// sorts in n odd-even transposition passes (n = loaded candidates), then
// picks one victim per cycle. Reset (synchronous) empties the chain.
// Results cannot be stalled; each appears on rsp_word for a single cycle.
module greedy_two_resource_victim_picker #(
   parameter int MAX_CANDIDATES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gtrvp_pkg::req_type req_word,
   output logic               rsp_strobe,
   output gtrvp_pkg::rsp_type rsp_word
);
   import gtrvp_pkg::*;

   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_CANDIDATES);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    pass_ff, pass_in;
   logic             by_ram_ff, by_ram_in;
   logic [SizeW-1:0] ram_need_ff, ram_need_in;
   logic [SizeW-1:0] disk_need_ff, disk_need_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctl_type ctl;
   cell_op_type  op;
   logic         accept;
   logic         load;
   logic [CW-1:0] count_after;
   logic [SizeW-1:0] ram_next;
   logic [SizeW-1:0] disk_next;
   logic         no_cover;
   entry_type    vic_entry;
   entry_type    new_entry;

   entry_type              entries [MAX_CANDIDATES];
   logic [MAX_CANDIDATES-1:0] occ;
   logic [MAX_CANDIDATES-1:0] swaps;
   logic [MAX_CANDIDATES-1:0] found;
   logic [MAX_CANDIDATES-1:0] shifts;
   logic [MAX_CANDIDATES-1:0] victims;
   logic [MAX_CANDIDATES-1:0] wr;

   // handshake and load
   assign accept      = start & ~busy;
   assign load        = accept & req_word.candidate_valid & (count_ff < MaxCount);
   assign count_after = count_ff + CW'(load);
   assign new_entry   = '{ram: req_word.candidate_ram, disk: req_word.candidate_disk,
                          id: req_word.candidate_id};

   assign ctl = '{op: op, by_ram: by_ram_ff, parity: pass_ff[0],
                  ram_need: ram_need_ff, disk_need: disk_need_ff};
   assign no_cover = ~found[MAX_CANDIDATES-1];

   // row of cells, occupied cells always form a prefix
   for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
      localparam logic [CW-1:0] Pos = CW'(i);
      entry_type left_e;
      entry_type right_e;
      logic      occ_r;
      logic      swap_l;
      logic      found_l;
      logic      shift_l;

      assign occ[i] = Pos < count_ff;
      assign wr[i]  = load & (count_ff == Pos);

      if (i == 0) begin : g_first
         assign left_e  = '0;
         assign swap_l  = 1'b0;
         assign found_l = 1'b0;
         assign shift_l = 1'b0;
      end else begin : g_mid
         assign left_e  = entries[i-1];
         assign swap_l  = swaps[i-1];
         assign found_l = found[i-1];
         assign shift_l = shifts[i-1];
      end

      if (i == MAX_CANDIDATES - 1) begin : g_last
         assign right_e = '0;
         assign occ_r   = 1'b0;
      end else begin : g_inner
         assign right_e = entries[i+1];
         assign occ_r   = occ[i+1];
      end

      gtrvp_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .no_cover   (no_cover),
         .wr         (wr[i]),
         .wr_entry   (new_entry),
         .occ        (occ[i]),
         .occ_right  (occ_r),
         .left_entry (left_e),
         .right_entry(right_e),
         .swap_in    (swap_l),
         .found_in   (found_l),
         .shift_in   (shift_l),
         .entry      (entries[i]),
         .swap_out   (swaps[i]),
         .found_out  (found[i]),
         .shift_out  (shifts[i]),
         .victim     (victims[i])
      );
   end

   // victim select: one-hot and-or over the row
   always_comb begin
      vic_entry = '0;
      for (int i = 0; i < MAX_CANDIDATES; i++) begin
         if (victims[i]) begin
            vic_entry = vic_entry | entries[i];
         end
      end
   end

   // saturating deficit update
   assign ram_next  = (vic_entry.ram >= ram_need_ff) ? '0 : ram_need_ff - vic_entry.ram;
   assign disk_next = (vic_entry.disk >= disk_need_ff) ? '0 : disk_need_ff - vic_entry.disk;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.set_last && count_after != '0 &&
                (req_word.ram_deficit != '0 || req_word.disk_deficit != '0)) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (CW'(pass_ff + 1'b1) == count_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (count_ff == CW'(1) || (ram_next == '0 && disk_next == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            op   = OP_HOLD;
         end
         ST_SORT: begin
            busy = 1'b1;
            op   = OP_SORT;
         end
         ST_PICK: begin
            busy = 1'b1;
            op   = OP_PICK;
         end
         default: begin
            busy = 1'b1;
            op   = OP_HOLD;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      count_in      = count_ff;
      pass_in       = pass_ff;
      by_ram_in     = by_ram_ff;
      ram_need_in   = ram_need_ff;
      disk_need_in  = disk_need_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            count_in = count_after;
            if (accept && req_word.set_last) begin
               ram_need_in  = req_word.ram_deficit;
               disk_need_in = req_word.disk_deficit;
               by_ram_in    = req_word.ram_deficit != '0;
               pass_in      = '0;
               if (state_in == ST_IDLE) begin
                  // nothing to do: one empty result
                  count_in      = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{victim_valid: 1'b0, victim_id: '0,
                                    ram_left: req_word.ram_deficit,
                                    disk_left: req_word.disk_deficit,
                                    result_last: 1'b1};
               end
            end
         end
         ST_SORT: begin
            pass_in = CW'(pass_ff + 1'b1);
         end
         ST_PICK: begin
            ram_need_in   = ram_next;
            disk_need_in  = disk_next;
            rsp_strobe_in = 1'b1;
            rsp_in        = '{victim_valid: 1'b1, victim_id: vic_entry.id,
                              ram_left: ram_next, disk_left: disk_next,
                              result_last: state_in == ST_IDLE};
            count_in      = (state_in == ST_IDLE) ? '0 : CW'(count_ff - 1'b1);
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pass_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pass_ff       <= pass_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      by_ram_ff    <= by_ram_in;
      ram_need_ff  <= ram_need_in;
      disk_need_ff <= disk_need_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
